>>> rtl/core/dlt_pkg.sv
// ----------------------------------------------------------------------------
// dlt_pkg
// Shared types and constants for the delta-list timer queue.
// ----------------------------------------------------------------------------
package dlt_pkg;

  localparam int DELTA_W     = 15;
  localparam int WORD_W      = 16;
  // upper bound on expiries reported by one tick
  localparam int MAX_RESULTS = 16;

  typedef struct packed {
    logic [DELTA_W-1:0] delta;
    logic [WORD_W-1:0]  handle;
    logic [WORD_W-1:0]  argument;
  } entry_t;

  typedef enum logic [1:0] {
    KIND_EXPIRED  = 2'd0,
    KIND_ACCEPTED = 2'd1,
    KIND_FULL     = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FULL,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_FIX,
    ST_SH_RD,
    ST_SH_WR,
    ST_INS,
    ST_DEC_RD,
    ST_DEC_CHK,
    ST_EXP_RD,
    ST_EXP_CHK,
    ST_EXP_END
  } state_e;

endpackage

>>> rtl/core/dlt_alu.sv
// ----------------------------------------------------------------------------
// dlt_alu
// Shared delta subtractor: difference and borrow (borrow = a < b).
// ----------------------------------------------------------------------------
module dlt_alu (
  input  logic [dlt_pkg::DELTA_W-1:0] a_i,
  input  logic [dlt_pkg::DELTA_W-1:0] b_i,
  output logic [dlt_pkg::DELTA_W-1:0] diff_o,
  output logic                        borrow_o
);

  logic [dlt_pkg::DELTA_W:0] full;

  assign full     = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o   = full[dlt_pkg::DELTA_W-1:0];
  assign borrow_o = full[dlt_pkg::DELTA_W];

endmodule

>>> rtl/core/dlt_mem.sv
// ----------------------------------------------------------------------------
// dlt_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dlt_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  dlt_pkg::entry_t  wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output dlt_pkg::entry_t  rd_data_o
);

  dlt_pkg::entry_t mem_q [DEPTH];
  dlt_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/core/delta_list_timer_queue_core.sv
// ----------------------------------------------------------------------------
// delta_list_timer_queue_core
// Callout queue kept as a delta list, run by a small sequencer.
// ----------------------------------------------------------------------------
// Each queued entry holds the ticks beyond the entry ahead of it plus a handle
// and an argument word. A schedule item (opcode 1) walks the list, inserts the
// new entry in time order (after any entry expiring at the same tick), trims
// the delta of its successor and answers with one item: accepted, or rejected
// when all QUEUE_DEPTH entries are in use. A tick item (opcode 0) decrements
// the first nonzero delta; unless deferred it then reports every leading
// zero-delta entry, oldest first, up to 16 per tick, and drops them; last
// marks the final item of a tick. Ticks on an empty queue or that expire
// nothing produce no item. The entries live in a single-port-write,
// registered-read memory arranged as a ring, so removing expired entries
// only moves the head pointer. The block takes one item at a time and holds
// in_stall_o high until it is done. A schedule reads each entry it passes,
// then moves each entry behind the insert point back one slot with a read
// and a write; a rejected schedule only answers, and a tick on an empty queue
// leaves the block idle. A tick reads each delta up to and including the
// first nonzero one (all of them when every delta is zero); unless deferred
// it then reads and reports the expired entries until a nonzero delta, the
// last entry or 16 expiries ends the scan. Read data from the memory is
// registered.
// A full output register that is stalled downstream pauses the sequencer only
// when it has a further item to hand over. No clearing pass is needed after
// reset: the entry count alone marks which entries are valid.
// ----------------------------------------------------------------------------
module delta_list_timer_queue_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [15:0] handle_i,
  input  logic [15:0] argument_i,
  input  logic [14:0] delay_i,
  input  logic        deferred_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [15:0] out_handle_o,
  output logic [15:0] out_argument_o,
  output logic        last_o
);

  localparam int AW = $clog2(QUEUE_DEPTH);     // ring address width
  localparam int CW = $clog2(QUEUE_DEPTH + 1); // counts 0..QUEUE_DEPTH
  localparam int SW = CW + 1;                  // head + offset

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  dlt_pkg::state_e state_q, state_d;

  logic [CW-1:0]               count_q, count_d;
  logic [AW-1:0]               head_q, head_d;
  logic [CW-1:0]               pos_q, pos_d;   // insert position
  logic [CW-1:0]               idx_q, idx_d;   // shift / scan / expiry index
  logic [dlt_pkg::DELTA_W-1:0] t_q, t_d;       // remaining delay
  logic [15:0]                 h_q, h_d;
  logic [15:0]                 a_q, a_d;
  logic                        def_q, def_d;

  // one expired entry held back until we know whether it is the last
  logic                        pend_q, pend_d;
  logic [15:0]                 pend_h_q, pend_h_d;
  logic [15:0]                 pend_a_q, pend_a_d;

  // output register
  logic                        out_valid_q, out_valid_d;
  dlt_pkg::kind_e              kind_q, kind_d;
  logic [15:0]                 oh_q, oh_d;
  logic [15:0]                 oa_q, oa_d;
  logic                        last_q, last_d;

  // --------------------------------------------------------------------------
  // Datapath pieces
  // --------------------------------------------------------------------------
  logic                        out_free;
  logic                        accept;
  logic                        full;

  logic [dlt_pkg::DELTA_W-1:0] alu_a, alu_b, alu_diff;
  logic                        alu_borrow;

  logic                        rd_en, wr_en;
  logic [CW-1:0]               rd_off, wr_off;
  logic [SW-1:0]               rd_sum, wr_sum;
  logic [AW-1:0]               rd_addr, wr_addr;
  dlt_pkg::entry_t             wr_data, rd_data;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != dlt_pkg::ST_IDLE);
  assign accept   = in_valid_i && !in_stall_o;
  assign full     = (count_q == CW'(QUEUE_DEPTH));

  dlt_alu u_alu (
    .a_i      (alu_a),
    .b_i      (alu_b),
    .diff_o   (alu_diff),
    .borrow_o (alu_borrow)
  );

  dlt_mem #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // ALU operand select
  always_comb begin
    alu_a = t_q;
    alu_b = rd_data.delta;
    unique case (state_q)
      dlt_pkg::ST_FIX: begin
        alu_a = rd_data.delta;
        alu_b = t_q;
      end
      dlt_pkg::ST_DEC_CHK: begin
        alu_a = rd_data.delta;
        alu_b = dlt_pkg::DELTA_W'(1);
      end
      default: begin
        alu_a = t_q;
        alu_b = rd_data.delta;
      end
    endcase
  end

  // ring addressing: logical index -> physical slot
  always_comb begin
    rd_off = idx_q;
    wr_off = idx_q;
    if (state_q == dlt_pkg::ST_WALK_RD) begin
      rd_off = pos_q;
    end else if (state_q == dlt_pkg::ST_SH_RD) begin
      rd_off = idx_q - CW'(1);
    end
    if (state_q == dlt_pkg::ST_FIX || state_q == dlt_pkg::ST_INS) begin
      wr_off = pos_q;
    end
    rd_sum = SW'(head_q) + SW'(rd_off);
    wr_sum = SW'(head_q) + SW'(wr_off);
    if (rd_sum >= SW'(QUEUE_DEPTH)) begin
      rd_sum = rd_sum - SW'(QUEUE_DEPTH);
    end
    if (wr_sum >= SW'(QUEUE_DEPTH)) begin
      wr_sum = wr_sum - SW'(QUEUE_DEPTH);
    end
  end

  assign rd_addr = rd_sum[AW-1:0];
  assign wr_addr = wr_sum[AW-1:0];

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dlt_pkg::ST_IDLE: begin
        if (accept) begin
          if (opcode_i) begin
            state_d = full ? dlt_pkg::ST_FULL : dlt_pkg::ST_WALK_RD;
          end else if (count_q != '0) begin
            state_d = dlt_pkg::ST_DEC_RD;
          end
        end
      end
      dlt_pkg::ST_FULL: begin
        if (out_free) state_d = dlt_pkg::ST_IDLE;
      end
      dlt_pkg::ST_WALK_RD: begin
        state_d = (pos_q < count_q) ? dlt_pkg::ST_WALK_CHK : dlt_pkg::ST_SH_RD;
      end
      dlt_pkg::ST_WALK_CHK: begin
        state_d = alu_borrow ? dlt_pkg::ST_FIX : dlt_pkg::ST_WALK_RD;
      end
      dlt_pkg::ST_FIX: begin
        state_d = dlt_pkg::ST_SH_RD;
      end
      dlt_pkg::ST_SH_RD: begin
        state_d = (idx_q > pos_q) ? dlt_pkg::ST_SH_WR : dlt_pkg::ST_INS;
      end
      dlt_pkg::ST_SH_WR: begin
        state_d = dlt_pkg::ST_SH_RD;
      end
      dlt_pkg::ST_INS: begin
        if (out_free) state_d = dlt_pkg::ST_IDLE;
      end
      dlt_pkg::ST_DEC_RD: begin
        state_d = dlt_pkg::ST_DEC_CHK;
      end
      dlt_pkg::ST_DEC_CHK: begin
        if (rd_data.delta != '0 || idx_q + CW'(1) == count_q) begin
          state_d = def_q ? dlt_pkg::ST_IDLE : dlt_pkg::ST_EXP_RD;
        end else begin
          state_d = dlt_pkg::ST_DEC_RD;
        end
      end
      dlt_pkg::ST_EXP_RD: begin
        if (idx_q < count_q && 32'(idx_q) < dlt_pkg::MAX_RESULTS) begin
          state_d = dlt_pkg::ST_EXP_CHK;
        end else begin
          state_d = dlt_pkg::ST_EXP_END;
        end
      end
      dlt_pkg::ST_EXP_CHK: begin
        if (rd_data.delta != '0) begin
          state_d = dlt_pkg::ST_EXP_END;
        end else if (!pend_q || out_free) begin
          state_d = dlt_pkg::ST_EXP_RD;
        end
      end
      dlt_pkg::ST_EXP_END: begin
        if (!pend_q || out_free) state_d = dlt_pkg::ST_IDLE;
      end
      default: state_d = dlt_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and output updates
  // --------------------------------------------------------------------------
  always_comb begin
    count_d     = count_q;
    head_d      = head_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    t_d         = t_q;
    h_d         = h_q;
    a_d         = a_q;
    def_d       = def_q;
    pend_d      = pend_q;
    pend_h_d    = pend_h_q;
    pend_a_d    = pend_a_q;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    oh_d        = oh_q;
    oa_d        = oa_q;
    last_d      = last_q;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_data     = rd_data;

    unique case (state_q)
      dlt_pkg::ST_IDLE: begin
        if (accept) begin
          t_d    = delay_i;
          h_d    = handle_i;
          a_d    = argument_i;
          def_d  = deferred_i;
          pos_d  = '0;
          idx_d  = opcode_i ? count_q : '0;
          pend_d = 1'b0;
        end
      end
      dlt_pkg::ST_FULL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = dlt_pkg::KIND_FULL;
          oh_d        = '0;
          oa_d        = '0;
          last_d      = 1'b1;
        end
      end
      dlt_pkg::ST_WALK_RD: begin
        rd_en = (pos_q < count_q);
      end
      dlt_pkg::ST_WALK_CHK: begin
        // entry expires no later than the new one: pass it
        if (!alu_borrow) begin
          t_d   = alu_diff;
          pos_d = pos_q + CW'(1);
        end
      end
      dlt_pkg::ST_FIX: begin
        // successor keeps only the ticks beyond the new entry
        wr_en         = 1'b1;
        wr_data.delta = alu_diff;
      end
      dlt_pkg::ST_SH_RD: begin
        rd_en = (idx_q > pos_q);
      end
      dlt_pkg::ST_SH_WR: begin
        wr_en = 1'b1;
        idx_d = idx_q - CW'(1);
      end
      dlt_pkg::ST_INS: begin
        if (out_free) begin
          wr_en            = 1'b1;
          wr_data.delta    = t_q;
          wr_data.handle   = h_q;
          wr_data.argument = a_q;
          count_d          = count_q + CW'(1);
          out_valid_d      = 1'b1;
          kind_d           = dlt_pkg::KIND_ACCEPTED;
          oh_d             = '0;
          oa_d             = '0;
          last_d           = 1'b1;
        end
      end
      dlt_pkg::ST_DEC_RD: begin
        rd_en = 1'b1;
      end
      dlt_pkg::ST_DEC_CHK: begin
        if (rd_data.delta != '0) begin
          wr_en         = 1'b1;
          wr_data.delta = alu_diff;
          idx_d         = '0;
        end else if (idx_q + CW'(1) == count_q) begin
          idx_d = '0;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      dlt_pkg::ST_EXP_RD: begin
        rd_en = (idx_q < count_q) && (32'(idx_q) < dlt_pkg::MAX_RESULTS);
      end
      dlt_pkg::ST_EXP_CHK: begin
        if (rd_data.delta == '0 && (!pend_q || out_free)) begin
          if (pend_q) begin
            out_valid_d = 1'b1;
            kind_d      = dlt_pkg::KIND_EXPIRED;
            oh_d        = pend_h_q;
            oa_d        = pend_a_q;
            last_d      = 1'b0;
          end
          pend_d   = 1'b1;
          pend_h_d = rd_data.handle;
          pend_a_d = rd_data.argument;
          idx_d    = idx_q + CW'(1);
        end
      end
      dlt_pkg::ST_EXP_END: begin
        if (pend_q && out_free) begin
          out_valid_d = 1'b1;
          kind_d      = dlt_pkg::KIND_EXPIRED;
          oh_d        = pend_h_q;
          oa_d        = pend_a_q;
          last_d      = 1'b1;
          pend_d      = 1'b0;
          head_d      = wr_addr;        // head advanced past the expired run
          count_d     = count_q - idx_q;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dlt_pkg::ST_IDLE;
      count_q     <= '0;
      head_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_q      <= head_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    idx_q    <= idx_d;
    t_q      <= t_d;
    h_q      <= h_d;
    a_q      <= a_d;
    def_q    <= def_d;
    pend_h_q <= pend_h_d;
    pend_a_q <= pend_a_d;
    kind_q   <= kind_d;
    oh_q     <= oh_d;
    oa_q     <= oa_d;
    last_q   <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign out_handle_o   = oh_q;
  assign out_argument_o = oa_q;
  assign last_o         = last_q;

endmodule
